[hdl/rtttl_pkg.sv]
package rtttl_pkg;

    // One request: a text character and the restart flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       restart;
    } rtttl_in_t;

    // One result: a finished note or rest, and/or the end of the song.
    typedef struct packed {
        logic        note_valid;
        logic        is_rest;
        logic [14:0] timer_divider;
        logic [15:0] duration_ms;
        logic        song_end;
    } rtttl_out_t;

    typedef enum logic [3:0] {
        PH_NAME,
        PH_HEADER,
        PH_START,
        PH_LEN1,
        PH_LEN2,
        PH_LETTER,
        PH_SHARP,
        PH_DOT1,
        PH_OCT,
        PH_DONE,
        PH_ENDED
    } phase_t;

    typedef enum logic [1:0] {
        KEY_NONE,
        KEY_D,
        KEY_O,
        KEY_B
    } hkey_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_Q1_GO,
        CTL_Q1_RUN,
        CTL_Q2_GO,
        CTL_Q2_RUN,
        CTL_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic rest;
        logic dot;
        logic pend;
    } tok_flags_t;

    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_resp_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;

    localparam logic [6:0] DEF_LEN    = 7'd4;
    localparam logic [3:0] DEF_OCTAVE = 4'd6;
    localparam logic [9:0] DEF_TEMPO  = 10'd63;

    localparam logic [3:0] OCT_LOW  = 4'd4;
    localparam logic [3:0] OCT_HIGH = 4'd7;

    localparam logic [DIV_W-1:0] MS_PER_MIN = 16'd60000;
    localparam logic [15:0]      DUR_MAX    = 16'hFFFF;

    // 8 MHz timer compare values, 8000000 / f - 1, octaves 4 to 7.
    localparam logic [14:0] TONE_DIV [4][12] = '{
        '{15'd30533, 15'd28879, 15'd27209, 15'd25722, 15'd24241, 15'd22921,
          15'd21620, 15'd20407, 15'd19276, 15'd18180, 15'd17166, 15'd16193},
        '{15'd15295, 15'd14439, 15'd13627, 15'd12860, 15'd12138, 15'd11460,
          15'd10809, 15'd10203, 15'd9637,  15'd9089,  15'd8582,  15'd8096},
        '{15'd7639,  15'd7212,  15'd6807,  15'd6429,  15'd6064,  15'd5725,
          15'd5404,  15'd5101,  15'd4818,  15'd4544,  15'd4288,  15'd4047},
        '{15'd3821,  15'd3605,  15'd3404,  15'd3213,  15'd3032,  15'd2862,
          15'd2701,  15'd2550,  15'd2408,  15'd2271,  15'd2144,  15'd2023}
    };

    localparam logic [3:0] PITCH_B = 4'd11;
    localparam logic [3:0] PITCH_N = 4'd12;

    // Clamps the octave and turns a sharpened B into C of the next octave, except at the top.
    function automatic logic [14:0] note_divider(input logic [3:0] octave,
                                                 input logic [3:0] pitch);
        logic [1:0] row;
        logic [3:0] col;
        if (octave < OCT_LOW) begin
            row = 2'd0;
        end else if (octave > OCT_HIGH) begin
            row = 2'd3;
        end else begin
            row = 2'(octave - OCT_LOW);
        end
        col = pitch;
        if (pitch >= PITCH_N) begin
            if (row != 2'd3) begin
                row = row + 2'd1;
                col = 4'd0;
            end else begin
                col = PITCH_B;
            end
        end
        return TONE_DIV[row][col];
    endfunction

endpackage

[hdl/rtttl_note_parser_unit.sv]
// RTTTL ringtone parser: takes the ringtone text one character per request and
// returns one result for each finished note or rest (timer divider for an
// 8 MHz tone timer and duration in milliseconds) and one for the ending NUL.
// A character that closes no note is accepted and s_ready stays high.
// A character that closes a note holds s_ready low until the sequencer is idle
// again: two 16-step divisions, 60000/tempo and then by the note length, run on
// one shared bit-serial divider, each after its own start state, and then the
// EMIT state loads the output register; with a zero tempo or length the
// divisions are skipped and only EMIT follows, as it does for a bare song end.
// A further wait applies only while the previous result is still not taken.
module rtttl_note_parser_unit
    import rtttl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rtttl_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rtttl_out_t m_data
);

    // Parser state.
    phase_t     phase_reg, phase_next, cur_phase;
    logic [6:0] dlen_reg, dlen_next, cur_dlen;
    logic [3:0] doct_reg, doct_next, cur_doct;
    logic [9:0] tempo_reg, tempo_next, cur_tempo;
    logic [6:0] tlen_reg, tlen_next, cur_tlen;
    logic [3:0] pitch_reg, pitch_next, cur_pitch;
    logic [3:0] toct_reg, toct_next, cur_toct;
    tok_flags_t flags_reg, flags_next, cur_flags;
    hkey_t      key_reg, key_next, cur_key;
    logic [1:0] hdig_reg, hdig_next, cur_hdig;

    // Sequencer and work registers.
    ctl_state_t state_reg, state_next;
    logic        work_note_reg, work_note_next;
    logic        work_rest_reg, work_rest_next;
    logic        work_end_reg, work_end_next;
    logic        work_dot_reg, work_dot_next;
    logic [6:0]  work_len_reg, work_len_next;
    logic [14:0] work_div_reg, work_div_next;
    logic [15:0] dur_reg, dur_next;
    logic        out_valid_reg, out_valid_next;
    rtttl_out_t  out_data_reg, out_data_next;

    logic       s_fire;
    logic       is_dig;
    logic [3:0] dv;
    logic [3:0] letter_pitch;
    logic       letter_ok;
    logic       res_fire;
    logic       res_note;
    logic       res_end;
    logic       note_rest;
    logic       zero_div;
    logic       emit_load;

    logic [17:0] dur4;
    logic [19:0] dur6;
    logic [18:0] scaled;

    div_req_t  div_req;
    div_resp_t div_resp;

    rtttl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    assign s_fire = s_valid && s_ready;
    assign is_dig = (s_data.ch >= CH_ZERO) && (s_data.ch <= CH_NINE);
    assign dv     = s_data.ch[3:0];

    always_comb begin
        letter_ok    = 1'b1;
        letter_pitch = 4'd0;
        case (s_data.ch)
            CH_C:    letter_pitch = 4'd0;
            CH_D:    letter_pitch = 4'd2;
            CH_E:    letter_pitch = 4'd4;
            CH_F:    letter_pitch = 4'd5;
            CH_G:    letter_pitch = 4'd7;
            CH_A:    letter_pitch = 4'd9;
            CH_B:    letter_pitch = PITCH_B;
            default: letter_ok = 1'b0;
        endcase
    end

    // A restart request sees the reset state before its character is parsed.
    always_comb begin
        if (s_data.restart) begin
            cur_phase = PH_NAME;
            cur_dlen  = DEF_LEN;
            cur_doct  = DEF_OCTAVE;
            cur_tempo = DEF_TEMPO;
            cur_tlen  = '0;
            cur_pitch = '0;
            cur_toct  = '0;
            cur_flags = '0;
            cur_key   = KEY_NONE;
            cur_hdig  = '0;
        end else begin
            cur_phase = phase_reg;
            cur_dlen  = dlen_reg;
            cur_doct  = doct_reg;
            cur_tempo = tempo_reg;
            cur_tlen  = tlen_reg;
            cur_pitch = pitch_reg;
            cur_toct  = toct_reg;
            cur_flags = flags_reg;
            cur_key   = key_reg;
            cur_hdig  = hdig_reg;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        dlen_next  = dlen_reg;
        doct_next  = doct_reg;
        tempo_next = tempo_reg;
        tlen_next  = tlen_reg;
        pitch_next = pitch_reg;
        toct_next  = toct_reg;
        flags_next = flags_reg;
        key_next   = key_reg;
        hdig_next  = hdig_reg;
        res_fire   = 1'b0;
        res_note   = 1'b0;
        res_end    = 1'b0;
        note_rest  = 1'b0;
        if (s_fire) begin
            phase_next = cur_phase;
            dlen_next  = cur_dlen;
            doct_next  = cur_doct;
            tempo_next = cur_tempo;
            tlen_next  = cur_tlen;
            pitch_next = cur_pitch;
            toct_next  = cur_toct;
            flags_next = cur_flags;
            key_next   = cur_key;
            hdig_next  = cur_hdig;
            if (cur_phase == PH_ENDED) begin
                phase_next = PH_ENDED;
            end else if (cur_phase == PH_NAME || cur_phase == PH_HEADER) begin
                if (s_data.ch == CH_NUL) begin
                    res_fire   = 1'b1;
                    res_end    = 1'b1;
                    phase_next = PH_ENDED;
                end else if (cur_phase == PH_NAME) begin
                    if (s_data.ch == CH_COLON) begin
                        phase_next = PH_HEADER;
                    end
                end else if (s_data.ch == CH_COLON) begin
                    key_next   = KEY_NONE;
                    phase_next = PH_START;
                end else if (s_data.ch == CH_COMMA) begin
                    key_next = KEY_NONE;
                end else if (cur_key == KEY_NONE) begin
                    hdig_next = '0;
                    if (s_data.ch == CH_D) begin
                        key_next  = KEY_D;
                        dlen_next = '0;
                    end else if (s_data.ch == CH_O) begin
                        key_next  = KEY_O;
                        doct_next = '0;
                    end else if (s_data.ch == CH_B) begin
                        key_next   = KEY_B;
                        tempo_next = '0;
                    end
                end else if (is_dig) begin
                    if (cur_key == KEY_D && cur_hdig < 2'd2) begin
                        dlen_next = 7'(cur_dlen * 7'd10 + {3'b000, dv});
                        hdig_next = cur_hdig + 2'd1;
                    end else if (cur_key == KEY_O && cur_hdig < 2'd1) begin
                        doct_next = dv;
                        hdig_next = cur_hdig + 2'd1;
                    end else if (cur_key == KEY_B && cur_hdig < 2'd3) begin
                        tempo_next = 10'(cur_tempo * 10'd10 + {6'b000000, dv});
                        hdig_next  = cur_hdig + 2'd1;
                    end
                end
            end else if (s_data.ch == CH_NUL || s_data.ch == CH_COMMA) begin
                if (cur_flags.pend || s_data.ch == CH_NUL) begin
                    res_fire = 1'b1;
                end
                if (cur_flags.pend) begin
                    res_note  = 1'b1;
                    // A token of length digits only is a rest.
                    note_rest = cur_flags.rest
                             || cur_phase == PH_LEN1 || cur_phase == PH_LEN2;
                end
                flags_next = '0;
                if (s_data.ch == CH_NUL) begin
                    res_end    = 1'b1;
                    phase_next = PH_ENDED;
                end else begin
                    phase_next = PH_START;
                end
            end else if (s_data.ch != CH_SPACE) begin
                case (cur_phase)
                    PH_START: begin
                        tlen_next       = cur_dlen;
                        toct_next       = cur_doct;
                        pitch_next      = '0;
                        flags_next      = '0;
                        flags_next.pend = 1'b1;
                        if (is_dig) begin
                            tlen_next  = {3'b000, dv};
                            phase_next = PH_LEN1;
                        end else begin
                            pitch_next      = letter_pitch;
                            flags_next.rest = !letter_ok;
                            phase_next      = PH_LETTER;
                        end
                    end
                    PH_LEN1: begin
                        if (is_dig) begin
                            tlen_next  = 7'(cur_tlen * 7'd10 + {3'b000, dv});
                            phase_next = PH_LEN2;
                        end else begin
                            pitch_next      = letter_pitch;
                            flags_next.rest = cur_flags.rest || !letter_ok;
                            phase_next      = PH_LETTER;
                        end
                    end
                    PH_LEN2: begin
                        pitch_next      = letter_pitch;
                        flags_next.rest = cur_flags.rest || !letter_ok;
                        phase_next      = PH_LETTER;
                    end
                    PH_LETTER, PH_SHARP, PH_DOT1: begin
                        if (cur_phase == PH_LETTER && s_data.ch == CH_HASH) begin
                            if (!cur_flags.rest) begin
                                pitch_next = cur_pitch + 4'd1;
                            end
                            phase_next = PH_SHARP;
                        end else if (cur_phase != PH_DOT1 && s_data.ch == CH_DOT) begin
                            flags_next.dot = 1'b1;
                            phase_next     = PH_DOT1;
                        end else if (is_dig) begin
                            toct_next  = dv;
                            phase_next = PH_OCT;
                        end else if (cur_phase == PH_DOT1 && s_data.ch == CH_DOT) begin
                            flags_next.dot = 1'b1;
                            phase_next     = PH_DONE;
                        end
                    end
                    PH_OCT: begin
                        if (s_data.ch == CH_DOT) begin
                            flags_next.dot = 1'b1;
                            phase_next     = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign zero_div = (tempo_reg == '0) || (cur_tlen == '0);

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE: begin
                if (s_fire && res_fire) begin
                    if (res_note && !zero_div) begin
                        state_next = CTL_Q1_GO;
                    end else begin
                        state_next = CTL_EMIT;
                    end
                end
            end
            CTL_Q1_GO:  state_next = CTL_Q1_RUN;
            CTL_Q1_RUN: begin
                if (div_resp.done) begin
                    state_next = CTL_Q2_GO;
                end
            end
            CTL_Q2_GO:  state_next = CTL_Q2_RUN;
            CTL_Q2_RUN: begin
                if (div_resp.done) begin
                    state_next = CTL_EMIT;
                end
            end
            CTL_EMIT: begin
                if (emit_load) begin
                    state_next = CTL_IDLE;
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_ready          = (state_reg == CTL_IDLE);
        div_req.start    = (state_reg == CTL_Q1_GO) || (state_reg == CTL_Q2_GO);
        div_req.dividend = MS_PER_MIN;
        div_req.divisor  = {6'b000000, tempo_reg};
        if (state_reg == CTL_Q2_GO) begin
            div_req.dividend = div_resp.quotient;
            div_req.divisor  = {9'b000000000, work_len_reg};
        end
        emit_load = (state_reg == CTL_EMIT) && (!out_valid_reg || m_ready);
    end

    // Duration: quotient times four, times one and a half when dotted.
    always_comb begin
        dur4   = {div_resp.quotient, 2'b00};
        dur6   = {2'b00, dur4} + {1'b0, dur4, 1'b0};
        scaled = work_dot_reg ? dur6[19:1] : {1'b0, dur4};
    end

    always_comb begin
        work_note_next = work_note_reg;
        work_rest_next = work_rest_reg;
        work_end_next  = work_end_reg;
        work_dot_next  = work_dot_reg;
        work_len_next  = work_len_reg;
        work_div_next  = work_div_reg;
        dur_next       = dur_reg;
        if (state_reg == CTL_IDLE && s_fire && res_fire) begin
            work_note_next = res_note;
            work_rest_next = res_note && note_rest;
            work_end_next  = res_end;
            work_dot_next  = cur_flags.dot;
            work_len_next  = cur_tlen;
            work_div_next  = (res_note && !note_rest)
                           ? note_divider(cur_toct, cur_pitch) : '0;
            dur_next       = (res_note && zero_div) ? DUR_MAX : '0;
        end else if (state_reg == CTL_Q2_RUN && div_resp.done) begin
            dur_next = (scaled[18:16] != '0) ? DUR_MAX : scaled[15:0];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit_load) begin
            out_valid_next              = 1'b1;
            out_data_next.note_valid    = work_note_reg;
            out_data_next.is_rest       = work_rest_reg;
            out_data_next.timer_divider = work_div_reg;
            out_data_next.duration_ms   = dur_reg;
            out_data_next.song_end      = work_end_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_NAME;
            dlen_reg      <= DEF_LEN;
            doct_reg      <= DEF_OCTAVE;
            tempo_reg     <= DEF_TEMPO;
            tlen_reg      <= '0;
            pitch_reg     <= '0;
            toct_reg      <= '0;
            flags_reg     <= '0;
            key_reg       <= KEY_NONE;
            hdig_reg      <= '0;
            state_reg     <= CTL_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            dlen_reg      <= dlen_next;
            doct_reg      <= doct_next;
            tempo_reg     <= tempo_next;
            tlen_reg      <= tlen_next;
            pitch_reg     <= pitch_next;
            toct_reg      <= toct_next;
            flags_reg     <= flags_next;
            key_reg       <= key_next;
            hdig_reg      <= hdig_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        work_note_reg <= work_note_next;
        work_rest_reg <= work_rest_next;
        work_end_reg  <= work_end_next;
        work_dot_reg  <= work_dot_next;
        work_len_reg  <= work_len_next;
        work_div_reg  <= work_div_next;
        dur_reg       <= dur_next;
        out_data_reg  <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[hdl/rtttl_div.sv]
module rtttl_div
    import rtttl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  div_req_t  req,
    output div_resp_t resp
);

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       partial;
    logic [DIV_W:0]       trial;

    // Restoring division, one quotient bit per cycle, MSB first.
    always_comb begin
        partial   = {rem_reg, quo_reg[DIV_W-1]};
        trial     = partial - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start && !busy_reg) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_W]) begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = partial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

endmodule

[hdl/rtttl_checker.sv]
module rtttl_checker
    import rtttl_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input rtttl_in_t  s_data,
    input logic       m_valid,
    input logic       m_ready,
    input rtttl_out_t m_data
);

    // A result waiting on the output holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    // Only a comma or a NUL can close a note, so any other request leaves the input open.
    a_plain_char: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.ch != CH_NUL && s_data.ch != CH_COMMA |=> s_ready)
        else $error("input blocked after a request that closes nothing");

    // A result without a note is only ever the end of the song.
    a_bare_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.note_valid |-> m_data.song_end && !m_data.is_rest
            && m_data.timer_divider == '0 && m_data.duration_ms == '0)
        else $error("empty result is not a clean song end");

    a_rest_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.note_valid |->
            (m_data.is_rest == (m_data.timer_divider == '0)))
        else $error("rest flag and timer divider disagree");

endmodule

bind rtttl_note_parser_unit rtttl_checker u_rtttl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/rtttl_note_parser_unit_tb.sv]
module rtttl_note_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtttl_pkg::*;

    localparam int ITEM_TARGET  = 1800;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_GAP      = 20;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_TOP    = 8'hFF;

    // Note frequencies in Hz, octaves 4 to 7, twelve semitones each.
    localparam int unsigned PITCH_HZ [48] = '{
        262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
        523, 554, 587, 622, 659, 698, 740, 784, 830, 880, 932, 988,
        1047, 1109, 1175, 1244, 1319, 1397, 1480, 1568, 1660, 1760, 1865, 1976,
        2093, 2218, 2349, 2489, 2637, 2794, 2960, 3136, 3320, 3520, 3728, 3951
    };

    typedef struct packed {
        rtttl_in_t  req;
        logic       known;
        logic       has;
        rtttl_out_t res;
    } dir_row_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    rtttl_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    rtttl_out_t m_data;

    rtttl_note_parser_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Parser state as the testbench tracks it.
    phase_t     song_phase;
    logic [6:0] len_default;
    logic [3:0] oct_default;
    logic [9:0] bpm;
    logic [6:0] tok_len;
    logic [3:0] tok_pitch;
    logic [3:0] tok_oct;
    tok_flags_t tok_fl;
    hkey_t      hdr_key;
    logic [1:0] hdr_digits;

    rtttl_out_t notes_due [$];
    dir_row_t   song_rows [$];

    int errors      = 0;
    int live_items  = 0;
    int notes_seen  = 0;
    int ends_seen   = 0;
    int songs       = 0;
    int send_idle   = 0;
    int recv_stall  = 0;
    int cycle_count = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    function automatic void clear_parser();
        song_phase  = PH_NAME;
        len_default = DEF_LEN;
        oct_default = DEF_OCTAVE;
        bpm         = DEF_TEMPO;
        tok_len     = '0;
        tok_pitch   = '0;
        tok_oct     = '0;
        tok_fl      = '0;
        hdr_key     = KEY_NONE;
        hdr_digits  = '0;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Builds the note or rest for the token that is being closed.
    function automatic rtttl_out_t note_result();
        rtttl_out_t  r;
        int unsigned dur;
        int unsigned oct;
        int unsigned p;
        r = '0;
        r.note_valid = 1'b1;
        if (bpm == 0 || tok_len == 0) begin
            dur = 65535;
        end else begin
            dur = (60000 / int'(bpm)) / int'(tok_len) * 4;
            if (tok_fl.dot) begin
                dur = dur * 3 / 2;
            end
            if (dur > 65535) begin
                dur = 65535;
            end
        end
        r.duration_ms = dur[15:0];
        if (tok_fl.rest) begin
            r.is_rest = 1'b1;
        end else begin
            oct = 32'(tok_oct);
            p   = 32'(tok_pitch);
            if (oct < 4) oct = 4;
            if (oct > 7) oct = 7;
            // A sharpened B rolls over into C of the next octave, except at the top.
            if (p >= 12) begin
                if (oct < 7) begin
                    oct = oct + 1;
                    p   = 0;
                end else begin
                    p = 11;
                end
            end
            r.timer_divider = 15'(8000000 / PITCH_HZ[(oct - 4) * 12 + p] - 1);
        end
        return r;
    endfunction

    function automatic void take_letter(logic [7:0] c);
        case (c)
            CH_C: tok_pitch = 4'd0;
            CH_D: tok_pitch = 4'd2;
            CH_E: tok_pitch = 4'd4;
            CH_F: tok_pitch = 4'd5;
            CH_G: tok_pitch = 4'd7;
            CH_A: tok_pitch = 4'd9;
            CH_B: tok_pitch = 4'd11;
            default: begin
                tok_pitch   = 4'd0;
                tok_fl.rest = 1'b1;
            end
        endcase
        song_phase = PH_LETTER;
    endfunction

    task automatic parse_char(input rtttl_in_t req, output logic has, output rtttl_out_t res);
        logic [7:0] c;
        logic [3:0] dv;
        logic       pend;
        c   = req.ch;
        dv  = 4'(c - CH_ZERO);
        has = 1'b0;
        res = '0;
        if (req.restart) clear_parser();
        if (song_phase == PH_ENDED) return;

        if (song_phase == PH_NAME || song_phase == PH_HEADER) begin
            if (c == CH_NUL) begin
                has          = 1'b1;
                res.song_end = 1'b1;
                song_phase   = PH_ENDED;
            end else if (song_phase == PH_NAME) begin
                if (c == CH_COLON) song_phase = PH_HEADER;
            end else if (c == CH_COLON) begin
                hdr_key    = KEY_NONE;
                song_phase = PH_START;
            end else if (c == CH_COMMA) begin
                hdr_key = KEY_NONE;
            end else if (hdr_key == KEY_NONE) begin
                hdr_digits = '0;
                if (c == CH_D) begin
                    hdr_key     = KEY_D;
                    len_default = '0;
                end else if (c == CH_O) begin
                    hdr_key     = KEY_O;
                    oct_default = '0;
                end else if (c == CH_B) begin
                    hdr_key = KEY_B;
                    bpm     = '0;
                end
            end else if (is_digit(c)) begin
                if (hdr_key == KEY_D && hdr_digits < 2) begin
                    len_default = 7'(len_default * 10 + dv);
                    hdr_digits++;
                end else if (hdr_key == KEY_O && hdr_digits < 1) begin
                    oct_default = dv;
                    hdr_digits++;
                end else if (hdr_key == KEY_B && hdr_digits < 3) begin
                    bpm = 10'(bpm * 10 + dv);
                    hdr_digits++;
                end
            end
            return;
        end

        if (c == CH_NUL || c == CH_COMMA) begin
            pend = tok_fl.pend;
            if (pend || c == CH_NUL) begin
                has = 1'b1;
                if (pend) begin
                    // Only length digits seen: the token is a rest of that length.
                    if (song_phase == PH_LEN1 || song_phase == PH_LEN2) tok_fl.rest = 1'b1;
                    res = note_result();
                end
            end
            tok_fl = '0;
            if (c == CH_NUL) begin
                res.song_end = 1'b1;
                song_phase   = PH_ENDED;
            end else begin
                song_phase = PH_START;
            end
            return;
        end
        if (c == CH_SPACE) return;

        case (song_phase)
            PH_START: begin
                tok_len   = len_default;
                tok_oct   = oct_default;
                tok_pitch = '0;
                tok_fl    = '0;
                tok_fl.pend = 1'b1;
                if (is_digit(c)) begin
                    tok_len    = 7'(dv);
                    song_phase = PH_LEN1;
                end else begin
                    take_letter(c);
                end
            end
            PH_LEN1: begin
                if (is_digit(c)) begin
                    tok_len    = 7'(tok_len * 10 + dv);
                    song_phase = PH_LEN2;
                end else begin
                    take_letter(c);
                end
            end
            PH_LEN2: take_letter(c);
            PH_LETTER, PH_SHARP, PH_DOT1: begin
                if (song_phase == PH_LETTER && c == CH_HASH) begin
                    if (!tok_fl.rest) tok_pitch++;
                    song_phase = PH_SHARP;
                end else if (song_phase != PH_DOT1 && c == CH_DOT) begin
                    tok_fl.dot = 1'b1;
                    song_phase = PH_DOT1;
                end else if (is_digit(c)) begin
                    tok_oct    = dv;
                    song_phase = PH_OCT;
                end else if (c == CH_DOT && song_phase == PH_DOT1) begin
                    tok_fl.dot = 1'b1;
                    song_phase = PH_DONE;
                end
            end
            PH_OCT: begin
                if (c == CH_DOT) begin
                    tok_fl.dot = 1'b1;
                    song_phase = PH_DONE;
                end
            end
            default: ;
        endcase
    endtask

    function automatic dir_row_t step_row(logic [7:0] c, logic rs);
        dir_row_t r;
        r = '0;
        r.req.ch      = c;
        r.req.restart = rs;
        return r;
    endfunction

    function automatic dir_row_t known_row(logic [7:0] c, logic rs, logic has, logic nv,
                                           logic rest, logic [14:0] dvd, logic [15:0] dur,
                                           logic se);
        dir_row_t r;
        r = step_row(c, rs);
        r.known             = 1'b1;
        r.has               = has;
        r.res.note_valid    = nv;
        r.res.is_rest       = rest;
        r.res.timer_divider = dvd;
        r.res.duration_ms   = dur;
        r.res.song_end      = se;
        return r;
    endfunction

    function automatic logic [7:0] letter_code(int unsigned idx);
        case (idx)
            0: return CH_C;
            1: return CH_D;
            2: return CH_E;
            3: return CH_F;
            4: return CH_G;
            5: return CH_A;
            6: return CH_B;
            default: return CH_P;
        endcase
    endfunction

    // The first character of every song carries restart.
    task automatic add_ch(logic [7:0] c);
        song_rows.push_back(step_row(c, song_rows.size() == 0));
    endtask

    task automatic add_digit(int unsigned lo, int unsigned hi);
        add_ch(CH_ZERO + 8'($urandom_range(hi, lo)));
    endtask

    task automatic build_song();
        int n_tok;
        int nd;
        int k;
        int unsigned pick;
        song_rows.delete();

        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(30, 5)) begin
                song_rows.push_back(step_row(8'($urandom_range(255)),
                                             song_rows.size() == 0 || $urandom_range(15) == 0));
            end
            return;
        end

        repeat ($urandom_range(4)) add_ch(CH_A + 8'($urandom_range(25)));
        if ($urandom_range(40) == 0) add_ch(CH_NUL);
        add_ch(CH_COLON);

        if ($urandom_range(2) != 0) begin
            add_ch(CH_D);
            add_ch(CH_EQUALS);
            if ($urandom_range(9) == 0) nd = $urandom_range(1) ? 0 : 3;
            else nd = $urandom_range(2, 1);
            repeat (nd) add_digit(0, 9);
            if ($urandom_range(9) != 0) add_ch(CH_COMMA);
        end
        if ($urandom_range(7) == 0) add_ch(CH_SPACE);
        if ($urandom_range(2) != 0) begin
            add_ch(CH_O);
            add_ch(CH_EQUALS);
            if ($urandom_range(9) != 0) begin
                if ($urandom_range(3) == 0) add_digit(0, 9);
                else add_digit(4, 7);
            end
            if ($urandom_range(9) != 0) add_ch(CH_COMMA);
        end
        if ($urandom_range(2) != 0) begin
            add_ch(CH_B);
            add_ch(CH_EQUALS);
            if ($urandom_range(9) == 0) nd = $urandom_range(1) ? 0 : 4;
            else nd = $urandom_range(3, 1);
            repeat (nd) add_digit(0, 9);
        end
        add_ch(CH_COLON);

        n_tok = $urandom_range(10, 1);
        for (k = 0; k < n_tok; k++) begin
            if (k > 0) add_ch(CH_COMMA);
            if ($urandom_range(11) == 0) continue;
            if ($urandom_range(7) == 0) add_ch(CH_SPACE);
            pick = $urandom_range(11);
            if (pick >= 6) add_digit(0, 9);
            if (pick >= 9) add_digit(0, 9);
            if (pick == 11) add_digit(0, 9);
            if ($urandom_range(19) == 0) continue;
            if ($urandom_range(14) == 0) add_ch(8'($urandom_range(255)));
            else add_ch(letter_code($urandom_range(7)));
            if ($urandom_range(2) == 0) add_ch(CH_HASH);
            if ($urandom_range(3) == 0) add_ch(CH_DOT);
            if ($urandom_range(1) != 0) begin
                if ($urandom_range(3) == 0) add_digit(0, 9);
                else add_digit(4, 7);
            end
            if ($urandom_range(4) == 0) add_ch(CH_DOT);
            if ($urandom_range(19) == 0) add_ch(8'($urandom_range(126, 33)));
        end
        if ($urandom_range(9) != 0) add_ch(CH_NUL);
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(3, 1)) add_ch(8'($urandom_range(255)));
        end
    endtask

    // Offers one request, with a random idle gap first, and records what it should produce.
    task automatic push_request(input dir_row_t row);
        int         gap;
        logic       has;
        logic       live;
        rtttl_out_t res;
        gap = 0;
        while ($urandom_range(99) < send_idle && gap < MAX_GAP) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= row.req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        live = (song_phase != PH_ENDED) || row.req.restart;
        parse_char(row.req, has, res);
        if (row.known) begin
            has = row.has;
            res = row.res;
        end
        if (has) notes_due.push_back(res);
        if (live) live_items++;
    endtask

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        rtttl_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (notes_due.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, m_data);
            end else begin
                want = notes_due.pop_front();
                check_field("note_valid", 32'(want.note_valid), 32'(m_data.note_valid));
                check_field("is_rest", 32'(want.is_rest), 32'(m_data.is_rest));
                check_field("timer_divider", 32'(want.timer_divider),
                            32'(m_data.timer_divider));
                check_field("duration_ms", 32'(want.duration_ms), 32'(m_data.duration_ms));
                check_field("song_end", 32'(want.song_end), 32'(m_data.song_end));
                if (m_data.note_valid) notes_seen++;
                if (m_data.song_end) ends_seen++;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    initial begin
        dir_row_t opening_rows [$];
        int       ph;
        clear_parser();

        // NUL as the very first character, then a character after the end.
        opening_rows.push_back(known_row(CH_NUL, 1'b1, 1'b1, 1'b0, 1'b0, '0, '0, 1'b1));
        opening_rows.push_back(known_row(CH_TOP, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0));
        // Header "b" without digits leaves a zero tempo.
        opening_rows.push_back(step_row(CH_TOP, 1'b1));
        opening_rows.push_back(step_row(CH_COLON, 1'b0));
        opening_rows.push_back(step_row(CH_B, 1'b0));
        opening_rows.push_back(step_row(CH_COLON, 1'b0));
        // Sharp on a rest stays a rest.
        opening_rows.push_back(step_row(CH_P, 1'b0));
        opening_rows.push_back(step_row(CH_HASH, 1'b0));
        opening_rows.push_back(known_row(CH_COMMA, 1'b0, 1'b1, 1'b1, 1'b1, '0, 16'hFFFF, 1'b0));
        // B sharp in the top octave stays on B7.
        opening_rows.push_back(step_row(CH_B, 1'b0));
        opening_rows.push_back(step_row(CH_HASH, 1'b0));
        opening_rows.push_back(step_row(CH_ZERO + 8'd7, 1'b0));
        opening_rows.push_back(known_row(CH_COMMA, 1'b0, 1'b1, 1'b1, 1'b0, 15'd2023,
                                         16'hFFFF, 1'b0));
        // A third length digit lands in the letter position, and NUL closes the rest.
        opening_rows.push_back(step_row(CH_ZERO + 8'd3, 1'b0));
        opening_rows.push_back(step_row(CH_ZERO + 8'd2, 1'b0));
        opening_rows.push_back(step_row(CH_ZERO + 8'd1, 1'b0));
        opening_rows.push_back(known_row(CH_NUL, 1'b0, 1'b1, 1'b1, 1'b1, '0, 16'hFFFF, 1'b1));
        // Default header, a dotted sixteenth, then an octave above the range.
        opening_rows.push_back(step_row(CH_COLON, 1'b1));
        opening_rows.push_back(step_row(CH_COLON, 1'b0));
        opening_rows.push_back(step_row(CH_ZERO + 8'd1, 1'b0));
        opening_rows.push_back(step_row(CH_ZERO + 8'd6, 1'b0));
        opening_rows.push_back(step_row(CH_A, 1'b0));
        opening_rows.push_back(step_row(CH_DOT, 1'b0));
        opening_rows.push_back(step_row(CH_COMMA, 1'b0));
        opening_rows.push_back(step_row(CH_E, 1'b0));
        opening_rows.push_back(step_row(CH_ZERO + 8'd9, 1'b0));
        opening_rows.push_back(step_row(CH_NUL, 1'b0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle  = 65;
                    recv_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall = 65;
                end
                default: begin
                    send_idle  = 25;
                    recv_stall = 25;
                end
            endcase
            if (ph == 0) begin
                foreach (opening_rows[i]) push_request(opening_rows[i]);
            end
            while (live_items < (ph + 1) * ITEM_TARGET / 4) begin
                build_song();
                foreach (song_rows[i]) push_request(song_rows[i]);
                songs++;
            end
        end
        s_valid <= 1'b0;

        while (notes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (notes_due.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, notes_due.size());
        end
        $display("Sent %0d live characters in %0d generated songs under four idle patterns.",
                 live_items, songs);
        $display("Checked %0d notes and %0d song ends, %0d mismatches.",
                 notes_seen, ends_seen, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
